// ===== design/sstf_pkg.sv =====
// Shared types and constants of the nearest-first request scheduler.
package sstf_pkg;

  localparam int unsigned CYL_W   = 8;
  localparam int unsigned MOVES_W = 14;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [MOVES_W-1:0] MOVES_CAP = '1;

  typedef struct packed {
    logic [1:0]       func;
    logic [CYL_W-1:0] cylinder;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CYL_W-1:0]   served_cylinder;
    logic [MOVES_W-1:0] total_moves;
    logic               last;
  } rsp_t;

  // What the nearest-neighbour unit sees of a run in progress.
  typedef struct packed {
    logic               has_lo;
    logic               has_hi;
    logic [CYL_W-1:0]   head;
    logic [CYL_W-1:0]   lo_val;
    logic [CYL_W-1:0]   hi_val;
    logic [MOVES_W-1:0] moves;
  } run_view_t;

  // The unit's decision for one step of a run.
  typedef struct packed {
    logic               go_down;
    logic [CYL_W-1:0]   nxt;
    logic [MOVES_W-1:0] moves;
  } pick_t;

endpackage

// ===== design/sstf_ram.sv =====
// Request store: one write port and two registered read ports.
module sstf_ram import sstf_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [CYL_W-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [CYL_W-1:0]         rdata_a_o,
  output logic [CYL_W-1:0]         rdata_b_o
);

  logic [CYL_W-1:0] mem_q [DEPTH];
  logic [CYL_W-1:0] rdata_a_q;
  logic [CYL_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/sstf_pick.sv =====
// Nearest-neighbour choice and saturating movement sum for one run step.
module sstf_pick import sstf_pkg::*; (
  input  run_view_t view_i,
  output pick_t     pick_o
);

  logic [CYL_W-1:0]   dist_lo;
  logic [CYL_W-1:0]   dist_hi;
  logic [CYL_W-1:0]   step_gap;
  logic               go_down;
  logic [CYL_W-1:0]   nxt;
  logic [MOVES_W:0]   sum;

  always_comb begin
    dist_lo = (view_i.head > view_i.lo_val) ? view_i.head - view_i.lo_val
                                            : view_i.lo_val - view_i.head;
    dist_hi = (view_i.head > view_i.hi_val) ? view_i.head - view_i.hi_val
                                            : view_i.hi_val - view_i.head;
    // A tie goes upward.
    go_down  = !view_i.has_hi || (view_i.has_lo && (dist_lo < dist_hi));
    nxt      = go_down ? view_i.lo_val : view_i.hi_val;
    step_gap = go_down ? dist_lo : dist_hi;
    sum      = {1'b0, view_i.moves} + (MOVES_W+1)'(step_gap);
    pick_o.go_down = go_down;
    pick_o.nxt     = nxt;
    pick_o.moves   = sum[MOVES_W] ? MOVES_CAP : sum[MOVES_W-1:0];
  end

endmodule

// ===== design/sstf_request_scheduler_top.sv =====
// Top level of the nearest-first (SSTF) request scheduler.
//
// The block holds an ascending sorted list of pending cylinder requests in a
// single on-chip memory with two registered read ports and one write port.
// A word is taken when start is high and busy is low; busy stays high until
// the last result word of that item has been driven. Every result word is on
// rsp_o for exactly one cycle, marked by rsp_valid_o, and the receiver must
// take it then, as there is no way to hold results back. The list is walked
// one entry per cycle through the registered read ports: an insert moves
// each entry above the new value up by one, from the top down; a remove
// scans up to the matching entry and then closes the gap one entry per
// cycle; a run scans to the head entry and then gives one result word per
// cycle, request_count words in total. An insert into an empty store, a full
// store, an empty store on remove or run, and the unused function code are
// answered without going busy (the unused code gives no result at all).
// Input cylinders above CYLINDER_MAX are clamped before any use. The store
// needs no clearing after reset: only entries below the request count are
// ever used.
module sstf_request_scheduler_top import sstf_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 64,
  parameter int unsigned CYLINDER_MAX = 199
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(MAX_REQUESTS);
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_REQUESTS);
  localparam logic [CYL_W-1:0] CLAMP_VAL =
    (CYLINDER_MAX > (2 ** CYL_W) - 1) ? '1 : CYL_W'(CYLINDER_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic [CYL_W-1:0]   val_q, val_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      lower_q, lower_d;
  logic [CW-1:0]      upper_q, upper_d;
  logic [CYL_W-1:0]   head_q, head_d;
  logic [MOVES_W-1:0] moves_q, moves_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [CYL_W-1:0]   wdata;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic [CYL_W-1:0]   rdata_a;
  logic [CYL_W-1:0]   rdata_b;

  run_view_t          view;
  pick_t              pick;

  logic [CYL_W-1:0]   in_val;
  logic [CW-1:0]      ptr_m1, ptr_m2, ptr_p1, ptr_p2, cnt_m1;
  logic [CW-1:0]      lo_nx, up_nx, lo_nx_m1;
  logic               run_done;

  sstf_ram #(
    .DEPTH(MAX_REQUESTS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // Port A carries the entry just below the served window and port B the
  // entry just above it, both read in the cycle before the decision.
  always_comb begin
    view.has_lo = (lower_q != '0);
    view.has_hi = (upper_q < count_q);
    view.head   = head_q;
    view.lo_val = rdata_a;
    view.hi_val = rdata_b;
    view.moves  = moves_q;
  end

  sstf_pick u_pick (
    .view_i(view),
    .pick_o(pick)
  );

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    in_val   = (32'(req_i.cylinder) > CYLINDER_MAX) ? CLAMP_VAL : req_i.cylinder;
    ptr_m1   = ptr_q - CW'(1);
    ptr_m2   = ptr_q - CW'(2);
    ptr_p1   = ptr_q + CW'(1);
    ptr_p2   = ptr_q + CW'(2);
    cnt_m1   = count_q - CW'(1);
    lo_nx    = pick.go_down ? lower_q - CW'(1) : lower_q;
    up_nx    = pick.go_down ? upper_q : upper_q + CW'(1);
    lo_nx_m1 = lo_nx - CW'(1);
    run_done = (lo_nx == '0) && (up_nx == count_q);

    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    lower_d     = lower_q;
    upper_d     = upper_q;
    head_d      = head_q;
    moves_d     = moves_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = ptr_q[AW-1:0];
    wdata       = val_q;
    raddr_a     = '0;
    raddr_b     = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d  = req_i.func;
          val_d = in_val;
          rsp_d.served_cylinder = in_val;
          rsp_d.total_moves     = '0;
          rsp_d.last            = 1'b1;
          case (req_i.func)
            FUNC_INSERT: begin
              rsp_valid_d = 1'b1;
              if (count_q == COUNT_MAX) begin
                rsp_d.status = ST_FULL;
              end else if (count_q == '0) begin
                rsp_d.status = ST_OK;
                we      = 1'b1;
                waddr   = '0;
                wdata   = in_val;
                count_d = CW'(1);
              end else begin
                rsp_valid_d = 1'b0;
                ptr_d   = count_q;
                raddr_a = cnt_m1[AW-1:0];
                state_d = S_INS;
              end
            end
            FUNC_REMOVE, FUNC_RUN: begin
              if (count_q == '0) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = ST_NOTFOUND;
              end else begin
                ptr_d   = '0;
                raddr_a = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Move entries above the new value up by one, from the top down.
      S_INS: begin
        we = 1'b1;
        if ((ptr_q == '0) || (rdata_a <= val_q)) begin
          wdata       = val_q;
          count_d     = count_q + CW'(1);
          rsp_valid_d = 1'b1;
          rsp_d.status = ST_OK;
          state_d     = S_IDLE;
        end else begin
          wdata   = rdata_a;
          ptr_d   = ptr_m1;
          raddr_a = ptr_m2[AW-1:0];
        end
      end

      S_SCAN: begin
        if (rdata_a == val_q) begin
          if (op_q == FUNC_REMOVE) begin
            if (ptr_p1 == count_q) begin
              count_d      = cnt_m1;
              rsp_valid_d  = 1'b1;
              rsp_d.status = ST_OK;
              state_d      = S_IDLE;
            end else begin
              raddr_a = ptr_p1[AW-1:0];
              state_d = S_DEL;
            end
          end else begin
            rsp_valid_d           = 1'b1;
            rsp_d.status          = ST_OK;
            rsp_d.served_cylinder = val_q;
            rsp_d.total_moves     = '0;
            rsp_d.last            = (count_q == CW'(1));
            if (count_q == CW'(1)) begin
              state_d = S_IDLE;
            end else begin
              lower_d = ptr_q;
              upper_d = ptr_p1;
              head_d  = val_q;
              moves_d = '0;
              raddr_a = ptr_m1[AW-1:0];
              raddr_b = ptr_p1[AW-1:0];
              state_d = S_RUN;
            end
          end
        end else if (ptr_p1 == count_q) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = ST_NOTFOUND;
          state_d      = S_IDLE;
        end else begin
          ptr_d   = ptr_p1;
          raddr_a = ptr_p1[AW-1:0];
        end
      end

      // Close the gap left by the removed entry, one entry per cycle.
      S_DEL: begin
        we    = 1'b1;
        wdata = rdata_a;
        ptr_d = ptr_p1;
        if (ptr_p2 == count_q) begin
          count_d      = cnt_m1;
          rsp_valid_d  = 1'b1;
          rsp_d.status = ST_OK;
          state_d      = S_IDLE;
        end else begin
          raddr_a = ptr_p2[AW-1:0];
        end
      end

      // One served request per cycle; the next reads follow the new window.
      S_RUN: begin
        lower_d               = lo_nx;
        upper_d               = up_nx;
        head_d                = pick.nxt;
        moves_d               = pick.moves;
        rsp_valid_d           = 1'b1;
        rsp_d.status          = ST_OK;
        rsp_d.served_cylinder = pick.nxt;
        rsp_d.total_moves     = pick.moves;
        rsp_d.last            = run_done;
        raddr_a               = lo_nx_m1[AW-1:0];
        raddr_b               = up_nx[AW-1:0];
        if (run_done) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lower_q     <= '0;
      upper_q     <= '0;
      head_q      <= '0;
      moves_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lower_q     <= lower_d;
      upper_q     <= upper_d;
      head_q      <= head_d;
      moves_q     <= moves_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    ptr_q <= ptr_d;
    rsp_q <= rsp_d;
  end

  // The request count never passes the store's capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_MAX)
    else $error("request count above capacity");

  // While a run is in progress there is always an unserved entry left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> ((lower_q != '0) || (upper_q < count_q)))
    else $error("run step with nothing left to serve");

  // The final word of an item is seen only once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.last) |-> !busy)
    else $error("last word while still busy");

  // A word that is not the last one belongs to a run still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.last) |-> (state_q == S_RUN))
    else $error("intermediate word outside a run");

endmodule

// ===== tb/sv/sstf_checker.sv =====
// Checker for the request scheduler: predicts every result word and compares.
`timescale 1ns / 1ps

module sstf_checker import sstf_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 64,
  parameter int unsigned CYLINDER_MAX = 199
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        rsp_valid_i,
  input  rsp_t        rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // The checker's own image of the sorted request list.
  logic [CYL_W-1:0] cyl_list [MAX_REQUESTS];
  int               cyl_count;

  rsp_t        expected_rsp [$];
  int unsigned n_fail = 0;
  int unsigned n_pending = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;

  function automatic int cyl_gap(logic [CYL_W-1:0] a, logic [CYL_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic void answer(logic [1:0] status, logic [CYL_W-1:0] cyl, int moves,
                                 logic last);
    rsp_t w;
    w.status          = status;
    w.served_cylinder = cyl;
    w.total_moves     = MOVES_W'(moves);
    w.last            = last;
    expected_rsp.push_back(w);
  endfunction

  // Works out the result words of one accepted word and updates the list.
  function automatic void schedule_answers(req_t w);
    logic [CYL_W-1:0] v;
    logic [CYL_W-1:0] pos;
    logic [CYL_W-1:0] nxt;
    int               i;
    int               lo;
    int               hi;
    int               moves;
    bit               down;
    v = (w.cylinder > CYLINDER_MAX) ? CYL_W'(CYLINDER_MAX) : w.cylinder;
    case (w.func)
      FUNC_INSERT: begin
        if (cyl_count >= MAX_REQUESTS) begin
          answer(ST_FULL, v, 0, 1'b1);
        end else begin
          i = cyl_count;
          while (i > 0 && cyl_list[i-1] > v) begin
            cyl_list[i] = cyl_list[i-1];
            i--;
          end
          cyl_list[i] = v;
          cyl_count++;
          answer(ST_OK, v, 0, 1'b1);
        end
      end
      FUNC_REMOVE: begin
        i = 0;
        while (i < cyl_count && cyl_list[i] != v) i++;
        if (i >= cyl_count) begin
          answer(ST_NOTFOUND, v, 0, 1'b1);
        end else begin
          for (; i + 1 < cyl_count; i++) cyl_list[i] = cyl_list[i+1];
          cyl_count--;
          answer(ST_OK, v, 0, 1'b1);
        end
      end
      FUNC_RUN: begin
        i = 0;
        while (i < cyl_count && cyl_list[i] != v) i++;
        if (i >= cyl_count) begin
          answer(ST_NOTFOUND, v, 0, 1'b1);
        end else begin
          pos   = cyl_list[i];
          lo    = i;
          hi    = i + 1;
          moves = 0;
          answer(ST_OK, pos, 0, (lo == 0 && hi >= cyl_count));
          while (lo > 0 || hi < cyl_count) begin
            if (lo == 0) begin
              down = 1'b0;
            end else if (hi >= cyl_count) begin
              down = 1'b1;
            end else begin
              // A tie goes upward.
              down = cyl_gap(pos, cyl_list[lo-1]) < cyl_gap(pos, cyl_list[hi]);
            end
            if (down) begin
              lo--;
              nxt = cyl_list[lo];
            end else begin
              nxt = cyl_list[hi];
              hi++;
            end
            moves = moves + cyl_gap(pos, nxt);
            if (moves > MOVES_CAP) moves = MOVES_CAP;
            pos = nxt;
            answer(ST_OK, pos, moves, (lo == 0 && hi >= cyl_count));
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    n_fail++;
    $display("%0t ns checker: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      cyl_count = 0;
      expected_rsp.delete();
      n_pending = 0;
    end else begin
      // A word taken at this edge is predicted before any result is matched.
      if (start_i && !busy_i) schedule_answers(req_i);
      if (rsp_valid_i) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: st %0d cyl %0d mv %0d l %0d",
                                    rsp_i.status, rsp_i.served_cylinder, rsp_i.total_moves,
                                    rsp_i.last));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_i.status, want.status));
          if (rsp_i.served_cylinder !== want.served_cylinder)
            report_mismatch($sformatf("served_cylinder %0d, expected %0d",
                                      rsp_i.served_cylinder, want.served_cylinder));
          if (rsp_i.total_moves !== want.total_moves)
            report_mismatch($sformatf("total_moves %0d, expected %0d",
                                      rsp_i.total_moves, want.total_moves));
          if (rsp_i.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", rsp_i.last, want.last));
        end
      end
      n_pending = expected_rsp.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the request scheduler testbench: stimulus, timing and the verdict.
`timescale 1ns / 1ps

module testbench;
  import sstf_pkg::*;

  localparam int unsigned MAX_REQUESTS = 64;
  localparam int unsigned CYLINDER_MAX = 199;

  // The one function code that the block ignores altogether.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Random words after the directed part, not counting ignored ones.
  localparam int RANDOM_WORDS = 330;
  // After the last expected word, the block may still be walking its list
  // (an insert or remove can walk the whole list), so we keep watching
  // for stray words long after it.
  localparam int DRAIN_CYCLES = 300;
  localparam int DRAIN_LIMIT  = 20000;
  // Slowest correct run: some 350 words, each with an idle gap, a scan of up
  // to 64 entries and 64 result words. Several times the time that takes is
  // allowed before we give up.
  localparam int TIMEOUT_NS   = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req;
  logic        rsp_valid;
  rsp_t        rsp;
  int unsigned fail_count;
  int unsigned pending;

  // Cylinders we believe are held, used only to aim runs and removes at
  // values that are present, so that runs get past the head lookup.
  logic [CYL_W-1:0] held_cyls [$];
  int               burst_left = 0;

  sstf_request_scheduler_top #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .CYLINDER_MAX (CYLINDER_MAX)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  sstf_checker #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .CYLINDER_MAX (CYLINDER_MAX)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .rsp_valid_i  (rsp_valid),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the whole run, in case the block locks up.
  initial begin
    #(TIMEOUT_NS);
    $display("testbench: FAIL");
    $finish;
  end

  // Keeps the list of held cylinders in step with a word that has been taken.
  // Cylinders above the range are clamped by the block, so we clamp too.
  function automatic void track_word(req_t w);
    logic [CYL_W-1:0] v;
    int               i;
    v = (w.cylinder > CYLINDER_MAX) ? CYL_W'(CYLINDER_MAX) : w.cylinder;
    if (w.func == FUNC_INSERT) begin
      if (held_cyls.size() < MAX_REQUESTS) held_cyls.push_back(v);
    end else if (w.func == FUNC_REMOVE) begin
      for (i = 0; i < held_cyls.size(); i++) begin
        if (held_cyls[i] == v) begin
          held_cyls.delete(i);
          break;
        end
      end
    end
  endfunction

  // Half of the values fall in a narrow band, which gives duplicates and
  // equal distances on both sides; a few sit at the top end or above it.
  function automatic logic [CYL_W-1:0] pick_cylinder();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return CYL_W'($urandom_range(0, 24));
    else if (r < 8) return CYL_W'($urandom_range(0, 199));
    else return CYL_W'($urandom_range(180, 255));
  endfunction

  function automatic logic [CYL_W-1:0] held_cylinder();
    if (held_cyls.size() == 0) return pick_cylinder();
    return held_cyls[$urandom_range(0, held_cyls.size() - 1)];
  endfunction

  // Offers one word and returns at the rising edge that takes it. Words go
  // out in bursts; between bursts start is dropped for a random number of
  // cycles and the request lines carry noise, which the block must ignore.
  task automatic send_word(input logic [1:0] func, input logic [CYL_W-1:0] cyl);
    req_t w;
    int   gap;
    w.func     = func;
    w.cylinder = cyl;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
        req   <= req_t'($bits(req_t)'($urandom));
      end
    end
    burst_left--;
    @(negedge clk_i);
    start <= 1'b1;
    req   <= w;
    do @(posedge clk_i); while (busy);
    track_word(w);
  endtask

  initial begin
    int          n_sent;
    int          phase_left;
    int          n_phase;
    int          fill_goal;
    int          waited;
    int unsigned pick;

    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part. Run and remove on an empty store, then the ignored
    // code, then a small set holding both range ends, a clamped value and a
    // duplicate. The run from 100 first takes the duplicate, then has neighbours
    // at 50 and 150, an equal distance either way, so the tie must go upward.
    send_word(FUNC_RUN,    8'd5);
    send_word(FUNC_REMOVE, 8'd5);
    send_word(FUNC_UNUSED, 8'd77);
    send_word(FUNC_INSERT, 8'd0);
    send_word(FUNC_INSERT, 8'd255);
    send_word(FUNC_INSERT, 8'd199);
    send_word(FUNC_INSERT, 8'd100);
    send_word(FUNC_INSERT, 8'd100);
    send_word(FUNC_INSERT, 8'd50);
    send_word(FUNC_INSERT, 8'd150);
    send_word(FUNC_RUN,    8'd100);
    // A head above the range is clamped and so starts at the top entry.
    send_word(FUNC_RUN,    8'd230);
    send_word(FUNC_RUN,    8'd0);
    // Only one of the two equal entries goes; the absent value is refused.
    send_word(FUNC_REMOVE, 8'd100);
    send_word(FUNC_REMOVE, 8'd7);
    send_word(FUNC_RUN,    8'd100);
    send_word(FUNC_RUN,    8'd42);
    send_word(FUNC_REMOVE, 8'd255);
    send_word(FUNC_RUN,    8'd50);

    // Random part, in phases that each aim at a fill level. Most phases keep
    // the store small; the second, and about one in five of the others, fill it
    // to capacity so that long runs and inserts into a full store occur.
    n_sent     = 0;
    phase_left = 0;
    n_phase    = 0;
    fill_goal  = 0;
    while (n_sent < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        n_phase++;
        if (n_phase == 2 || $urandom_range(0, 4) == 0) begin
          fill_goal  = MAX_REQUESTS;
          phase_left = 110;
        end else begin
          fill_goal  = $urandom_range(0, 12);
          phase_left = $urandom_range(20, 50);
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // The ignored code does not count as a word of the random part.
        send_word(FUNC_UNUSED, CYL_W'($urandom));
        continue;
      end
      phase_left--;
      n_sent++;
      if (pick < 14) begin
        // Noise: any operation on any value, mostly absent ones.
        send_word(2'($urandom_range(0, 2)), CYL_W'($urandom));
      end else if (held_cyls.size() < fill_goal) begin
        if (pick < 75) send_word(FUNC_INSERT, pick_cylinder());
        else if (pick < 92) send_word(FUNC_RUN, held_cylinder());
        else send_word(FUNC_REMOVE, held_cylinder());
      end else begin
        if (pick < 35) send_word(FUNC_INSERT, pick_cylinder());
        else if (pick < 75) send_word(FUNC_RUN, held_cylinder());
        else send_word(FUNC_REMOVE, held_cylinder());
      end
    end

    @(negedge clk_i);
    start <= 1'b0;

    // Let every expected word arrive, then watch a while for stray ones.
    for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
